### rtl/gbr_pkg.sv
package gbr_pkg;

  localparam int MAX_CHAR_WIDTH = 64;
  localparam int MAX_BANDS      = 8;
  localparam int GLYPH_BITS     = 8;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  typedef enum logic [1:0] {
    ACT_SET_PEN  = 2'd0,
    ACT_GLYPH    = 2'd1,
    ACT_END_CHAR = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLIPPED        = 3'd0,
    CFG_VARIABLE_WIDTH = 3'd1,
    CFG_FIXED_WIDTH    = 3'd2,
    CFG_LETTER_SPACING = 3'd3,
    CFG_LINE_BITS      = 3'd4,
    CFG_PIXEL_COLOR    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]           base_x;
    logic [15:0]           base_y;
    logic [GLYPH_BITS-1:0] bits;
    logic                  flip;
    logic [15:0]           color;
  } glyph_job_t;

endpackage

### rtl/gbr_front.sv
module gbr_front
  import gbr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [15:0]           in_pen_x_in,
  input  logic [15:0]           in_pen_y_in,
  input  logic [7:0]            in_glyph_bits,
  input  logic [5:0]            in_column,
  input  logic [2:0]            in_band,
  input  logic [5:0]            in_char_width,
  input  logic                  queue_full,
  output logic                  queue_push,
  output glyph_job_t            queue_job
);

  logic        flipped_r;
  logic        variable_width_r;
  logic [5:0]  fixed_width_r;
  logic [7:0]  letter_spacing_r;
  logic [3:0]  line_bits_r;
  logic [15:0] pixel_color_r;
  logic [15:0] pen_x_r, pen_x_nxt;
  logic [15:0] pen_y_r, pen_y_nxt;

  logic                  accept;
  logic [3:0]            nbits;
  logic [GLYPH_BITS:0]   mask_wide;
  logic [GLYPH_BITS-1:0] masked;
  logic                  in_range;
  logic [15:0]           band_off;
  logic [5:0]            adv_w;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    nbits     = (line_bits_r > 4'(GLYPH_BITS)) ? 4'(GLYPH_BITS) : line_bits_r;
    mask_wide = ((GLYPH_BITS+1)'(1) << nbits) - (GLYPH_BITS+1)'(1);
    masked    = in_glyph_bits & mask_wide[GLYPH_BITS-1:0];
    in_range  = (int'(in_column) < MAX_CHAR_WIDTH) && (int'(in_band) < MAX_BANDS);
    band_off  = 16'({in_band, 3'b000});
    adv_w     = variable_width_r ? in_char_width : fixed_width_r;

    queue_job.bits  = masked;
    queue_job.flip  = flipped_r;
    queue_job.color = pixel_color_r;
    if (flipped_r) begin
      queue_job.base_x = pen_x_r;
      queue_job.base_y = pen_y_r + 16'(in_column) + band_off;
    end else begin
      queue_job.base_x = pen_x_r + 16'(in_column);
      queue_job.base_y = pen_y_r + band_off;
    end

    queue_push = accept && (in_action == ACT_GLYPH) && in_range && (masked != '0);

    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    if (accept) begin
      case (in_action)
        ACT_SET_PEN: begin
          pen_x_nxt = in_pen_x_in;
          pen_y_nxt = in_pen_y_in;
        end
        ACT_END_CHAR: begin
          pen_x_nxt = pen_x_r + 16'(adv_w) + 16'(letter_spacing_r);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flipped_r        <= 1'b0;
      variable_width_r <= 1'b0;
      fixed_width_r    <= 6'd8;
      letter_spacing_r <= 8'd1;
      line_bits_r      <= 4'd8;
      pixel_color_r    <= 16'hFFFF;
      pen_x_r          <= '0;
      pen_y_r          <= '0;
    end else begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FLIPPED:        flipped_r        <= cfg_wdata[0];
          CFG_VARIABLE_WIDTH: variable_width_r <= cfg_wdata[0];
          CFG_FIXED_WIDTH:    fixed_width_r    <= cfg_wdata[5:0];
          CFG_LETTER_SPACING: letter_spacing_r <= cfg_wdata[7:0];
          CFG_LINE_BITS:      line_bits_r      <= cfg_wdata[3:0];
          CFG_PIXEL_COLOR:    pixel_color_r    <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

### rtl/gbr_queue.sv
module gbr_queue
  import gbr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  glyph_job_t push_job,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output glyph_job_t head_job
);

  glyph_job_t             slots_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_PTR_W:0]   count_r, count_nxt;

  assign full       = (count_r == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

### rtl/gbr_back.sv
module gbr_back
  import gbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  glyph_job_t  head_job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pixel_x,
  output logic [15:0] out_pixel_y,
  output logic [15:0] out_color,
  output logic        out_last
);

  logic                  work_valid_r, work_valid_nxt;
  glyph_job_t            work_r, work_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [15:0]           px_r, px_nxt;
  logic [15:0]           py_r, py_nxt;
  logic [15:0]           color_r, color_nxt;
  logic                  last_r, last_nxt;

  logic                  adv;
  logic                  produce;
  logic [2:0]            bit_idx;
  logic [GLYPH_BITS-1:0] rem;
  logic                  finishing;

  always_comb begin
    bit_idx = '0;
    for (int i = GLYPH_BITS - 1; i >= 0; i--) begin
      if (work_r.bits[i]) begin
        bit_idx = 3'(i);
      end
    end
    rem       = work_r.bits & (work_r.bits - 1'b1);
    adv       = !out_valid_r || out_ready;
    produce   = adv && work_valid_r;
    finishing = produce && (rem == '0);
    pop       = head_valid && (!work_valid_r || finishing);

    out_valid_nxt = out_valid_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    color_nxt     = color_r;
    last_nxt      = last_r;
    if (adv) begin
      out_valid_nxt = work_valid_r;
      color_nxt     = work_r.color;
      last_nxt      = (rem == '0);
      if (work_r.flip) begin
        px_nxt = work_r.base_x + 16'(bit_idx);
        py_nxt = work_r.base_y;
      end else begin
        px_nxt = work_r.base_x;
        py_nxt = work_r.base_y + 16'(bit_idx);
      end
    end

    work_valid_nxt = work_valid_r;
    work_nxt       = work_r;
    if (pop) begin
      work_valid_nxt = 1'b1;
      work_nxt       = head_job;
    end else if (produce) begin
      work_valid_nxt = (rem != '0);
      work_nxt.bits  = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      work_valid_r <= work_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r  <= work_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    color_r <= color_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_pixel_x = px_r;
  assign out_pixel_y = py_r;
  assign out_color   = color_r;
  assign out_last    = last_r;

  a_work_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    work_valid_r |-> (work_r.bits != '0))
    else $error("active glyph job has no pixels left");
  a_pop_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && work_valid_r) |-> finishing)
    else $error("job loaded over unfinished job");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(px_r) && $stable(py_r)
                                     && $stable(color_r) && $stable(last_r)))
    else $error("stalled pixel transaction changed");

endmodule

### rtl/glyph_bitmap_rasterizer_core.sv
// Glyph bitmap rasterizer core.
// Input channel (in_valid/in_ready): one transaction per action. Set-pen and
// end-of-character transactions update the pen and produce no pixels. A glyph
// byte transaction produces one pixel per set bit among the low line_bits
// bits, lowest bit first, with out_last marking the final pixel of that byte.
// Output channel (out_valid/out_ready): one pixel transaction per cycle at
// most. Configuration (cfg_we/cfg_index/cfg_wdata) writes one register per
// cycle and must only be used while the core is idle.
// Throughput: the front end takes one input transaction per cycle while the
// four-entry job queue has room; the back end emits one pixel per cycle while
// the output is not stalled, so a glyph byte occupies the back end until all of
// its pixels are out. The first pixel of a glyph byte passes through the job
// queue, the back end's work register and the output register.
// When out_ready is low the output register holds its pixel; the back end
// stalls, the queue fills, and in_ready drops once the queue is full.
// Reset (rst_n low, synchronous) clears the pen to (0,0), empties the queue
// and output, and restores every configuration register to its reset value.
module glyph_bitmap_rasterizer_core
  import gbr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [15:0]           in_pen_x_in,
  input  logic [15:0]           in_pen_y_in,
  input  logic [7:0]            in_glyph_bits,
  input  logic [5:0]            in_column,
  input  logic [2:0]            in_band,
  input  logic [5:0]            in_char_width,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_pixel_x,
  output logic [15:0]           out_pixel_y,
  output logic [15:0]           out_color,
  output logic                  out_last
);

  logic       queue_push;
  logic       queue_full;
  glyph_job_t push_job;
  glyph_job_t head_job;
  logic       head_valid;
  logic       pop;

  gbr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_pen_x_in   (in_pen_x_in),
    .in_pen_y_in   (in_pen_y_in),
    .in_glyph_bits (in_glyph_bits),
    .in_column     (in_column),
    .in_band       (in_band),
    .in_char_width (in_char_width),
    .queue_full    (queue_full),
    .queue_push    (queue_push),
    .queue_job     (push_job)
  );

  gbr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (queue_push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  gbr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_pixel_x (out_pixel_x),
    .out_pixel_y (out_pixel_y),
    .out_color   (out_color),
    .out_last    (out_last)
  );

endmodule

### test/tb_top.sv
module tb_top;
  import gbr_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 48;
  localparam int STALL_LIMIT = 4000;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [1:0]  act;
    logic [15:0] pen_x;
    logic [15:0] pen_y;
    logic [7:0]  bits;
    logic [5:0]  column;
    logic [2:0]  band;
    logic [5:0]  char_width;
  } glyph_item_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] color;
    logic        last;
  } pixel_t;

  class pixel_predictor;
    logic        flip;
    logic        var_w;
    logic [5:0]  fix_w;
    logic [7:0]  spacing;
    logic [3:0]  line_n;
    logic [15:0] color;
    logic [15:0] pen_x;
    logic [15:0] pen_y;
    pixel_t      expected[$];
    int          mismatches;

    function new();
      flip = 1'b0;
      var_w = 1'b0;
      fix_w = 6'd8;
      spacing = 8'd1;
      line_n = 4'd8;
      color = 16'hFFFF;
      pen_x = '0;
      pen_y = '0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_t r, logic [15:0] v);
      case (r)
        CFG_FLIPPED: begin
          flip = v[0];
        end
        CFG_VARIABLE_WIDTH: begin
          var_w = v[0];
        end
        CFG_FIXED_WIDTH: begin
          fix_w = v[5:0];
        end
        CFG_LETTER_SPACING: begin
          spacing = v[7:0];
        end
        CFG_LINE_BITS: begin
          line_n = v[3:0];
        end
        CFG_PIXEL_COLOR: begin
          color = v;
        end
        default: begin
        end
      endcase
    endfunction

    // Expand one accepted transaction into the pixels it must produce.
    function void take_item(glyph_item_t it);
      pixel_t     run[$];
      pixel_t     p;
      int         nb;
      logic [5:0] w;
      if (it.act == ACT_SET_PEN) begin
        pen_x = it.pen_x;
        pen_y = it.pen_y;
      end else if (it.act == ACT_END_CHAR) begin
        w = var_w ? it.char_width : fix_w;
        pen_x = pen_x + {10'd0, w} + {8'd0, spacing};
      end else if (it.act == ACT_GLYPH) begin
        nb = (line_n > GLYPH_BITS) ? GLYPH_BITS : int'(line_n);
        if (it.column < MAX_CHAR_WIDTH && it.band < MAX_BANDS) begin
          for (int b = 0; b < nb; b++) begin
            if (it.bits[b]) begin
              if (flip) begin
                p.x = pen_x + 16'(b);
                p.y = pen_y + {10'd0, it.column} + {10'd0, it.band, 3'b000};
              end else begin
                p.x = pen_x + {10'd0, it.column};
                p.y = pen_y + 16'(b) + {10'd0, it.band, 3'b000};
              end
              p.color = color;
              p.last = 1'b0;
              run.push_back(p);
            end
          end
        end
        if (run.size() > 0) begin
          run[run.size()-1].last = 1'b1;
        end
        foreach (run[i]) begin
          expected.push_back(run[i]);
        end
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("pixel with none pending: x=%0d y=%0d color=%h last=%0b",
                   got.x, got.y, got.color, got.last);
        end
      end else begin
        want = expected.pop_front();
        if (want != got) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("pixel mismatch: exp x=%0d y=%0d color=%h last=%0b, got x=%0d y=%0d color=%h last=%0b",
                     want.x, want.y, want.color, want.last,
                     got.x, got.y, got.color, got.last);
          end
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_action;
  logic [15:0]           in_pen_x_in;
  logic [15:0]           in_pen_y_in;
  logic [7:0]            in_glyph_bits;
  logic [5:0]            in_column;
  logic [2:0]            in_band;
  logic [5:0]            in_char_width;
  logic                  out_valid;
  logic                  out_ready;
  logic [15:0]           out_pixel_x;
  logic [15:0]           out_pixel_y;
  logic [15:0]           out_color;
  logic                  out_last;

  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;
  pixel_predictor pred = new();

  glyph_bitmap_rasterizer_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_pen_x_in  (in_pen_x_in),
    .in_pen_y_in  (in_pen_y_in),
    .in_glyph_bits(in_glyph_bits),
    .in_column    (in_column),
    .in_band      (in_band),
    .in_char_width(in_char_width),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel_x  (out_pixel_x),
    .out_pixel_y  (out_pixel_y),
    .out_color    (out_color),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pred.take_item('{act: in_action, pen_x: in_pen_x_in, pen_y: in_pen_y_in,
                         bits: in_glyph_bits, column: in_column, band: in_band,
                         char_width: in_char_width});
      end
      if (out_valid && out_ready) begin
        pred.check_pixel('{x: out_pixel_x, y: out_pixel_y, color: out_color,
                           last: out_last});
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic glyph_item_t rand_item();
    glyph_item_t it;
    it.act = 2'($urandom_range(3));
    it.pen_x = 16'($urandom());
    it.pen_y = 16'($urandom());
    it.bits = 8'($urandom());
    it.column = 6'($urandom());
    it.band = 3'($urandom());
    it.char_width = 6'($urandom());
    return it;
  endfunction

  function automatic glyph_item_t mk_pen(logic [15:0] x, logic [15:0] y);
    glyph_item_t it;
    it = rand_item();
    it.act = ACT_SET_PEN;
    it.pen_x = x;
    it.pen_y = y;
    return it;
  endfunction

  function automatic glyph_item_t mk_glyph(logic [7:0] bits, logic [5:0] col,
                                           logic [2:0] band);
    glyph_item_t it;
    it = rand_item();
    it.act = ACT_GLYPH;
    it.bits = bits;
    it.column = col;
    it.band = band;
    return it;
  endfunction

  function automatic glyph_item_t mk_end(logic [5:0] cw);
    glyph_item_t it;
    it = rand_item();
    it.act = ACT_END_CHAR;
    it.char_width = cw;
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input glyph_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_action = it.act;
    in_pen_x_in = it.pen_x;
    in_pen_y_in = it.pen_y;
    in_glyph_bits = it.bits;
    in_column = it.column;
    in_band = it.band;
    in_char_width = it.char_width;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_pixels();
    in_valid = 1'b0;
    while (pred.expected.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t r, input logic [15:0] v);
    cfg_we = 1'b1;
    cfg_index = r;
    cfg_wdata = v;
    pred.write_reg(r, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_settings(input logic fl, input logic vw, input logic [5:0] fw,
                                input logic [7:0] sp, input logic [3:0] lb,
                                input logic [15:0] col);
    drain_pixels();
    repeat (HOLD_CYCLES) @(negedge clk);
    cfg_write(CFG_FLIPPED, {15'd0, fl});
    cfg_write(CFG_VARIABLE_WIDTH, {15'd0, vw});
    cfg_write(CFG_FIXED_WIDTH, {10'd0, fw});
    cfg_write(CFG_LETTER_SPACING, {8'd0, sp});
    cfg_write(CFG_LINE_BITS, {12'd0, lb});
    cfg_write(CFG_PIXEL_COLOR, col);
  endtask

  // Mostly whole characters: pen, a few columns of bands, end; some noise.
  task automatic run_text(input int n_items);
    glyph_item_t it;
    int          sent;
    int          w;
    int          nbands;
    int          band0;
    int          sel;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        it = rand_item();
        send_item(it);
        if (it.act != ACT_UNUSED) sent++;
      end else begin
        if ($urandom_range(3) != 0) begin
          send_item(mk_pen(16'($urandom()), 16'($urandom())));
          sent++;
        end
        w = $urandom_range(1, 5);
        nbands = $urandom_range(1, 2);
        band0 = $urandom_range(0, 8 - nbands);
        for (int c = 0; c < w; c++) begin
          for (int bd = 0; bd < nbands; bd++) begin
            sel = $urandom_range(9);
            it = mk_glyph(8'($urandom()), 6'(c), 3'(band0 + bd));
            if (sel == 0) it.bits = 8'h00;
            if (sel == 1) it.bits = 8'hFF;
            send_item(it);
            sent++;
          end
        end
        if ($urandom_range(7) != 0) begin
          send_item(mk_end(6'($urandom())));
          sent++;
        end
      end
    end
  endtask

  initial begin
    glyph_item_t noise;
    cfg_we = 1'b0;
    cfg_index = CFG_FLIPPED;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_action = ACT_SET_PEN;
    in_pen_x_in = '0;
    in_pen_y_in = '0;
    in_glyph_bits = '0;
    in_column = '0;
    in_band = '0;
    in_char_width = '0;
    send_idle_pct = 23;
    recv_stall_pct = 86;
    quiet_cycles = 0;
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    send_item(mk_pen(16'h0000, 16'h0000));
    send_item(mk_glyph(8'hFF, 6'd0, 3'd0));
    send_item(mk_glyph(8'h00, 6'd5, 3'd1));
    send_item(mk_glyph(8'h80, 6'd63, 3'd7));
    send_item(mk_glyph(8'h01, 6'd1, 3'd0));
    send_item(mk_end(6'd17));
    send_item(mk_glyph(8'hAA, 6'd2, 3'd3));
    noise = rand_item();
    noise.act = ACT_UNUSED;
    send_item(noise);
    send_item(mk_glyph(8'h55, 6'd3, 3'd2));
    send_item(mk_pen(16'hFFFF, 16'hFFF8));
    send_item(mk_glyph(8'hFF, 6'd63, 3'd7));
    send_item(mk_end(6'd63));
    send_item(mk_glyph(8'h81, 6'd0, 3'd0));
    send_item(mk_pen(16'h8000, 16'h7FFF));
    send_item(mk_end(6'd0));
    send_item(mk_glyph(8'h7F, 6'd31, 3'd4));

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        1: apply_settings(1'b1, 1'b1, 6'd63, 8'd255, 4'd8, 16'h0000);
        2: apply_settings(1'b0, 1'b1, 6'd0, 8'd0, 4'd1, 16'hFFFF);
        3: apply_settings(1'b1, 1'b0, 6'd63, 8'd255, 4'd0, 16'($urandom()));
        4: apply_settings(1'b0, 1'b0, 6'd0, 8'd0, 4'd15, 16'($urandom()));
        default: apply_settings(1'($urandom()), 1'($urandom()), 6'($urandom()),
                                8'($urandom()), 4'($urandom_range(1, 8)),
                                16'($urandom()));
      endcase
      if (ph < 3) begin
        send_idle_pct = 23;
        recv_stall_pct = 86;
      end else if (ph < 6) begin
        send_idle_pct = 86;
        recv_stall_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      if (ph == 1) begin
        run_text(25);
        drain_pixels();
        run_text(25);
      end else begin
        run_text(50);
      end
    end

    drain_pixels();
    repeat (HOLD_CYCLES) @(negedge clk);
    if (pred.mismatches == 0 && pred.expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
